// ===== hw/rtl/cls_pkg.sv =====
// Shared types and constants for the combination lock with serial rekey.
package cls_pkg;

    localparam int CODE_LEN  = 3;
    localparam int FRAME_LEN = 7;

    // Event codes on the command channel
    localparam logic [1:0] CMD_DIGIT   = 2'd0;
    localparam logic [1:0] CMD_CONFIRM = 2'd1;
    localparam logic [1:0] CMD_SERIAL  = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_DASH = 8'h2D;

    localparam logic [3:0] DIGIT_MAX = 4'd9;
    localparam logic [7:0] FAIL_MAX  = 8'hFF;

    localparam logic [2:0] POS_NEW0 = 3'(CODE_LEN + 1);
    localparam logic [2:0] POS_NEW1 = 3'(CODE_LEN + 2);
    localparam logic [2:0] POS_LAST = 3'(FRAME_LEN - 1);

    typedef logic [CODE_LEN-1:0][7:0] code_t;
    typedef logic [2:0]               pos_t;
    typedef logic [3:0]               digit_t;

    // Entry 0 sits in the low byte
    localparam code_t CODE_RESET = {8'h33, 8'h32, 8'h31};

endpackage

// ===== hw/rtl/cls_cmd_if.sv =====
// Command channel: one key or serial event per item.
interface cls_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [1:0] key_index;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output key_index, output rx_byte, input ready);
    modport sink (input valid, input cmd, input key_index, input rx_byte, output ready);
endinterface

// ===== hw/rtl/cls_result_if.sv =====
// Result channel: lock status after each command item.
interface cls_result_if;
    logic       valid;
    logic       ready;
    logic       is_open;
    logic       entry_started;
    logic [3:0] entered_first;
    logic [3:0] entered_second;
    logic [3:0] entered_third;
    logic [7:0] wrong_tries;
    logic       code_changed;

    modport source (
        output valid, output is_open, output entry_started, output entered_first,
        output entered_second, output entered_third, output wrong_tries,
        output code_changed, input ready
    );
    modport sink (
        input valid, input is_open, input entry_started, input entered_first,
        input entered_second, input entered_third, input wrong_tries,
        input code_changed, output ready
    );
endinterface

// ===== hw/rtl/cls_rekey.sv =====
// Serial rekey frame parser; holds the stored code.
module cls_rekey
    import cls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] rx_byte,
    output code_t      stored_code,
    output logic       commit
);

    code_t      code_reg;
    pos_t       pos_reg;
    logic       good_reg;
    logic [7:0] pend0_reg;
    logic [7:0] pend1_reg;

    logic       allowed;
    logic       old_bad;
    logic       good_next;
    logic       last;

    always_comb
    begin
        allowed = ((rx_byte >= CHAR_0) && (rx_byte <= CHAR_9)) || (rx_byte == CHAR_DASH);
        case (pos_reg)
            3'd0:    old_bad = (rx_byte != code_reg[0]);
            3'd1:    old_bad = (rx_byte != code_reg[1]);
            3'd2:    old_bad = (rx_byte != code_reg[2]);
            default: old_bad = 1'b0;
        endcase
        good_next = good_reg && allowed && !old_bad;
        last      = (pos_reg >= POS_LAST);
        commit    = byte_en && last && good_next;
    end

    assign stored_code = code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= CODE_RESET;
            pos_reg  <= '0;
            good_reg <= 1'b1;
        end
        else if (byte_en)
        begin
            if (last)
            begin
                // close the frame; commit only a fully valid one
                if (good_next)
                begin
                    code_reg <= {rx_byte, pend1_reg, pend0_reg};
                end
                pos_reg  <= '0;
                good_reg <= 1'b1;
            end
            else
            begin
                pos_reg  <= pos_reg + 3'd1;
                good_reg <= good_next;
            end
        end
    end

    // new code bytes wait here until the last byte of the frame
    always_ff @(posedge clk)
    begin
        if (byte_en && (pos_reg == POS_NEW0))
        begin
            pend0_reg <= rx_byte;
        end
        if (byte_en && (pos_reg == POS_NEW1))
        begin
            pend1_reg <= rx_byte;
        end
    end

endmodule

// ===== hw/rtl/combination_lock_with_serial_rekey_top.sv =====
// Top level of the three-digit combination lock with serial rekey.
//
// Channels: cmd_ch takes one event item per handshake (digit key, confirm key
// or a received serial byte). result_ch returns exactly one status item per
// event: open flag, started flag, the three entered digits, the saturating
// wrong-try count and a flag that marks the byte completing a valid rekey
// frame.
// Status is registered: it appears in the cycle after its event is accepted.
// Throughput: one event per cycle unless result_ch stalls; state update and
// result are one pass of short logic from lock state to result register.
// Reset: the lock closes, the entered digits and wrong count clear, the
// stored code returns to "123" and the serial frame restarts at byte 0.
// Stall: the result register holds its item while result_ch.ready is low;
// cmd_ch.ready stays high as long as the result register is empty or being
// drained in the same cycle, so a stall on the result side stops intake after
// one item.
module combination_lock_with_serial_rekey_top
    import cls_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cls_cmd_if.sink      cmd_ch,
    cls_result_if.source result_ch
);

    logic   accept;
    logic   byte_en;
    logic   commit;
    code_t  stored_code;
    logic   match;

    digit_t entered_reg [CODE_LEN];
    digit_t entered_next [CODE_LEN];
    logic   started_reg, started_next;
    logic   open_reg, open_next;
    logic   [7:0] fail_reg, fail_next;

    logic   out_valid_reg;
    logic   res_open_reg;
    logic   res_started_reg;
    digit_t res_e0_reg, res_e1_reg, res_e2_reg;
    logic   [7:0] res_fail_reg;
    logic   res_changed_reg;

    // accept whenever the result register is empty or emptying now
    assign cmd_ch.ready = !out_valid_reg || result_ch.ready;
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign byte_en      = accept && (cmd_ch.cmd == CMD_SERIAL);

    cls_rekey u_rekey (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_en     (byte_en),
        .rx_byte     (cmd_ch.rx_byte),
        .stored_code (stored_code),
        .commit      (commit)
    );

    always_comb
    begin
        match = 1'b1;
        for (int k = 0; k < CODE_LEN; k++)
        begin
            if (stored_code[k] != (CHAR_0 + {4'b0000, entered_reg[k]}))
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < CODE_LEN; k++)
        begin
            entered_next[k] = entered_reg[k];
        end
        started_next = started_reg;
        open_next    = open_reg;
        fail_next    = fail_reg;

        unique case (cmd_ch.cmd)
            CMD_DIGIT:
            begin
                // step the chosen digit with wrap; keys are dead while open
                if (!open_reg)
                begin
                    for (int k = 0; k < CODE_LEN; k++)
                    begin
                        if (cmd_ch.key_index == 2'(k))
                        begin
                            entered_next[k] = (entered_reg[k] >= DIGIT_MAX) ? '0
                                              : entered_reg[k] + 4'd1;
                            started_next    = 1'b1;
                        end
                    end
                end
            end
            CMD_CONFIRM:
            begin
                if (!open_reg)
                begin
                    if (match)
                    begin
                        open_next = 1'b1;
                        fail_next = '0;
                    end
                    else
                    begin
                        started_next = 1'b0;
                        if (fail_reg != FAIL_MAX)
                        begin
                            fail_next = fail_reg + 8'd1;
                        end
                    end
                    for (int k = 0; k < CODE_LEN; k++)
                    begin
                        entered_next[k] = '0;
                    end
                end
            end
            CMD_SERIAL:
            begin
                // a committed rekey frame clears the wrong count
                if (commit)
                begin
                    fail_next = '0;
                end
            end
            CMD_NONE:
            begin
                // unused code: hold all state
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CODE_LEN; k++)
            begin
                entered_reg[k] <= '0;
            end
            started_reg   <= 1'b0;
            open_reg      <= 1'b0;
            fail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int k = 0; k < CODE_LEN; k++)
                begin
                    entered_reg[k] <= entered_next[k];
                end
                started_reg   <= started_next;
                open_reg      <= open_next;
                fail_reg      <= fail_next;
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_open_reg    <= open_next;
            res_started_reg <= started_next;
            res_e0_reg      <= entered_next[0];
            res_e1_reg      <= entered_next[1];
            res_e2_reg      <= entered_next[2];
            res_fail_reg    <= fail_next;
            res_changed_reg <= commit;
        end
    end

    assign result_ch.valid          = out_valid_reg;
    assign result_ch.is_open        = res_open_reg;
    assign result_ch.entry_started  = res_started_reg;
    assign result_ch.entered_first  = res_e0_reg;
    assign result_ch.entered_second = res_e1_reg;
    assign result_ch.entered_third  = res_e2_reg;
    assign result_ch.wrong_tries    = res_fail_reg;
    assign result_ch.code_changed   = res_changed_reg;

endmodule

// ===== verif/tb_combination_lock_with_serial_rekey_top.sv =====
// Self-checking testbench for the combination lock with serial rekey.
module tb_combination_lock_with_serial_rekey_top
    import cls_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Give up well past the slowest legal run.
    localparam int unsigned CYCLE_LIMIT = 400_000;

    // One lock status item as the result channel carries it
    typedef struct packed {
        logic       is_open;
        logic       entry_started;
        digit_t     entered_first;
        digit_t     entered_second;
        digit_t     entered_third;
        logic [7:0] wrong_tries;
        logic       code_changed;
    } lock_status_t;

    logic clk;
    logic rst_n;

    cls_cmd_if    cmd_ch ();
    cls_result_if result_ch ();

    combination_lock_with_serial_rekey_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_ch    (cmd_ch),
        .result_ch (result_ch)
    );

    // Shadow copy of the lock, advanced once per accepted item
    code_t        lk_code;
    digit_t       lk_digits [CODE_LEN];
    logic         lk_started;
    logic         lk_open;
    logic [7:0]   lk_fails;
    pos_t         lk_pos;
    logic         lk_frame_ok;
    logic [7:0]   lk_pending [2];

    // Lock status items predicted but not yet seen on the result channel
    lock_status_t status_q [$];

    int unsigned  src_idle_pct;
    int unsigned  snk_stall_pct;
    int unsigned  live_items;
    int unsigned  mismatches;
    int unsigned  cycles;

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: drop ready at the rate the current phase asks for.
    always @(posedge clk)
    begin
        result_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // True when the keyed entry spells the stored code.
    function automatic logic entry_matches();
        logic m;
        m = 1'b1;
        for (int i = 0; i < CODE_LEN; i++)
            if (lk_code[i] != CHAR_0 + 8'(lk_digits[i]))
                m = 1'b0;
        return m;
    endfunction

    // True when every stored character is a digit, so keys can reach it.
    function automatic logic code_keyable();
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < CODE_LEN; i++)
            if (lk_code[i] < CHAR_0 || lk_code[i] > CHAR_9)
                ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [7:0] random_code_char(int unsigned dash_pct);
        if ($urandom_range(0, 99) < dash_pct)
            return CHAR_DASH;
        return CHAR_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic code_t random_code(int unsigned dash_pct);
        code_t c;
        for (int i = 0; i < CODE_LEN; i++)
            c[i] = random_code_char(dash_pct);
        return c;
    endfunction

    // Advance the shadow lock by one event and return the status it reports.
    function automatic lock_status_t step_lock(logic [1:0] c, logic [1:0] k, logic [7:0] b);
        lock_status_t s;
        s.code_changed = 1'b0;
        case (c)
            CMD_DIGIT:
            begin
                if (!lk_open && k < CODE_LEN)
                begin
                    lk_digits[k] = (lk_digits[k] >= DIGIT_MAX) ? 4'd0 : lk_digits[k] + 4'd1;
                    lk_started   = 1'b1;
                end
            end
            CMD_CONFIRM:
            begin
                if (!lk_open)
                begin
                    if (entry_matches())
                    begin
                        lk_open  = 1'b1;
                        lk_fails = '0;
                    end
                    else
                    begin
                        lk_started = 1'b0;
                        if (lk_fails != FAIL_MAX)
                            lk_fails = lk_fails + 8'd1;
                    end
                    for (int i = 0; i < CODE_LEN; i++)
                        lk_digits[i] = '0;
                end
            end
            CMD_SERIAL:
            begin
                // Any illegal character or a wrong old-code byte spoils the frame,
                // but the frame still runs its full length.
                if (!((b >= CHAR_0 && b <= CHAR_9) || b == CHAR_DASH))
                    lk_frame_ok = 1'b0;
                if (lk_pos < CODE_LEN && b != lk_code[lk_pos])
                    lk_frame_ok = 1'b0;
                if (lk_pos >= POS_LAST)
                begin
                    if (lk_frame_ok)
                    begin
                        lk_code        = {b, lk_pending[1], lk_pending[0]};
                        lk_fails       = '0;
                        s.code_changed = 1'b1;
                    end
                    lk_pos      = '0;
                    lk_frame_ok = 1'b1;
                end
                else
                begin
                    if (lk_pos == POS_NEW0)
                        lk_pending[0] = b;
                    else if (lk_pos == POS_NEW1)
                        lk_pending[1] = b;
                    lk_pos = lk_pos + 3'd1;
                end
            end
            default: ;
        endcase
        s.is_open        = lk_open;
        s.entry_started  = lk_started;
        s.entered_first  = lk_digits[0];
        s.entered_second = lk_digits[1];
        s.entered_third  = lk_digits[2];
        s.wrong_tries    = lk_fails;
        return s;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every accepted status item with the oldest prediction.
    always @(posedge clk)
    begin : check_status
        lock_status_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (status_q.size() == 0)
            begin
                $error("lock status item with no prediction waiting");
                mismatches++;
            end
            else
            begin
                want = status_q.pop_front();
                check_field("is_open", want.is_open, result_ch.is_open);
                check_field("entry_started", want.entry_started, result_ch.entry_started);
                check_field("entered_first", want.entered_first, result_ch.entered_first);
                check_field("entered_second", want.entered_second, result_ch.entered_second);
                check_field("entered_third", want.entered_third, result_ch.entered_third);
                check_field("wrong_tries", want.wrong_tries, result_ch.wrong_tries);
                check_field("code_changed", want.code_changed, result_ch.code_changed);
            end
        end
    end

    // Offer one event item, hold it until accepted, then predict its status.
    // Valid is never lowered here: the next call or an idle cycle does that,
    // so back-to-back items keep valid high with a single assignment per edge.
    task automatic send_item(input logic [1:0] c, input logic [1:0] k, input logic [7:0] b);
        logic ignored;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.cmd       <= c;
        cmd_ch.key_index <= k;
        cmd_ch.rx_byte   <= b;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        // Items the lock drops on the floor do not count toward traffic totals
        ignored = (c == CMD_NONE) || (c == CMD_DIGIT && (lk_open || k >= CODE_LEN))
                  || (c == CMD_CONFIRM && lk_open);
        if (!ignored)
            live_items++;
        status_q.push_back(step_lock(c, k, b));
    endtask

    // Hold off the sender until every predicted status item has come back,
    // then let the result register settle.
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Step each digit key until the entry spells tgt, visiting keys from a
    // random starting point. Nothing moves while the lock is open.
    task automatic drive_entry(input digit_t tgt [CODE_LEN]);
        int unsigned first;
        logic [1:0]  k;
        first = $urandom_range(0, 2);
        for (int i = 0; i < CODE_LEN; i++)
        begin
            k = 2'((first + i) % CODE_LEN);
            while (!lk_open && lk_digits[k] != tgt[k])
                send_item(CMD_DIGIT, k, 8'($urandom_range(0, 255)));
        end
    endtask

    // Send a rekey frame: current code, separator, fresh code. Finish any
    // partial frame first so the old-code bytes line up with position 0.
    // A corrupt frame gets one byte replaced by an arbitrary value.
    task automatic send_rekey_frame(input logic [7:0] sep, input code_t fresh, input logic corrupt);
        logic [FRAME_LEN-1:0][7:0] frame;
        while (lk_pos != 0)
            send_item(CMD_SERIAL, 2'($urandom_range(0, 3)), random_code_char(10));
        frame = {fresh, sep, lk_code};
        if (corrupt)
            frame[$urandom_range(0, FRAME_LEN - 1)] = 8'($urandom_range(0, 255));
        for (int i = 0; i < FRAME_LEN; i++)
            send_item(CMD_SERIAL, 2'($urandom_range(0, 3)), frame[i]);
    endtask

    // Ignored commands, digit stepping with the 9-to-0 wrap, a failed confirm.
    task automatic test_key_entry();
        send_item(CMD_NONE, 2'd3, 8'hFF);
        send_item(CMD_DIGIT, 2'd3, 8'h00);
        repeat (10) send_item(CMD_DIGIT, 2'd2, 8'hA5);
        send_item(CMD_DIGIT, 2'd0, 8'h5A);
        send_item(CMD_DIGIT, 2'd1, 8'h00);
        send_item(CMD_CONFIRM, 2'd0, 8'h00);
    endtask

    // Rekey to a code holding a dash with a digit separator, then back to
    // the reset code with a dash separator.
    task automatic test_rekey_frames();
        send_rekey_frame(CHAR_9, {CHAR_9, CHAR_DASH, CHAR_0}, 1'b0);
        send_rekey_frame(CHAR_DASH, CODE_RESET, 1'b0);
    endtask

    // Mixed traffic: keyed attempts near the stored code, rekey frames (some
    // broken), raw noise and lone key presses. With keep_closed set, a confirm
    // that would open the lock is steered away so key handling stays live.
    task automatic test_random_traffic(input int unsigned n, input logic keep_closed);
        int unsigned start;
        int unsigned sel;
        int unsigned j;
        digit_t      tgt [CODE_LEN];
        logic [1:0]  c;
        start = live_items;
        while (live_items - start < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                if (code_keyable() && $urandom_range(0, 1))
                begin
                    for (int i = 0; i < CODE_LEN; i++)
                        tgt[i] = 4'(lk_code[i] - CHAR_0);
                    // Near miss: bump one digit off the stored value
                    if ($urandom_range(0, 1))
                    begin
                        j = $urandom_range(0, 2);
                        tgt[j] = 4'((int'(tgt[j]) + $urandom_range(1, 9)) % 10);
                    end
                end
                else
                begin
                    for (int i = 0; i < CODE_LEN; i++)
                        tgt[i] = 4'($urandom_range(0, 9));
                end
                drive_entry(tgt);
                if (keep_closed && entry_matches())
                    send_item(CMD_DIGIT, 2'($urandom_range(0, 2)), 8'h00);
                send_item(CMD_CONFIRM, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else if (sel < 60)
            begin
                send_rekey_frame(random_code_char(30), random_code(10),
                                 $urandom_range(0, 99) < 30);
            end
            else if (sel < 85)
            begin
                c = 2'($urandom_range(0, 3));
                if (keep_closed && c == CMD_CONFIRM && entry_matches())
                    c = CMD_DIGIT;
                send_item(c, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_item(CMD_DIGIT, 2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Drive the wrong-try count past its ceiling with failed confirms only.
    task automatic test_wrong_count_saturation();
        repeat (280)
        begin
            if ($urandom_range(0, 1))
                send_item(CMD_DIGIT, 2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)));
            if (entry_matches())
                send_item(CMD_DIGIT, 2'($urandom_range(0, 2)), 8'h00);
            send_item(CMD_CONFIRM, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // Open the lock with the stored code, show keys are dead while open and
    // that a rekey frame still goes through.
    task automatic test_open_lock();
        digit_t tgt [CODE_LEN];
        if (!code_keyable())
            send_rekey_frame(CHAR_DASH, random_code(0), 1'b0);
        for (int i = 0; i < CODE_LEN; i++)
            tgt[i] = 4'(lk_code[i] - CHAR_0);
        drive_entry(tgt);
        send_item(CMD_CONFIRM, 2'd0, 8'h00);
        send_item(CMD_DIGIT, 2'd0, 8'h00);
        send_item(CMD_CONFIRM, 2'd1, 8'h00);
        send_rekey_frame(CHAR_0, random_code(30), 1'b0);
    endtask

    initial
    begin
        // Command inputs known from time zero; reset held low before the run starts
        rst_n            = 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.cmd       <= CMD_NONE;
        cmd_ch.key_index <= '0;
        cmd_ch.rx_byte   <= '0;
        cycles           = 0;
        mismatches       = 0;
        live_items       = 0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;

        lk_code     = CODE_RESET;
        lk_started  = 1'b0;
        lk_open     = 1'b0;
        lk_fails    = '0;
        lk_pos      = '0;
        lk_frame_ok = 1'b1;
        lk_pending  = '{default: '0};
        for (int i = 0; i < CODE_LEN; i++)
            lk_digits[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed work and a first random stretch with no idling at all
        test_key_entry();
        test_rekey_frames();
        test_random_traffic(200, 1'b1);

        // Sender mostly idle
        src_idle_pct  = 83;
        snk_stall_pct = 0;
        test_random_traffic(350, 1'b1);

        // Receiver mostly stalling
        src_idle_pct  = 0;
        snk_stall_pct = 83;
        test_wrong_count_saturation();

        // Let every outstanding status come home before the lock opens for good
        drain_results();

        // Both sides idling
        src_idle_pct  = 36;
        snk_stall_pct = 36;
        test_open_lock();
        test_random_traffic(250, 1'b0);

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/cls_pkg.sv
hw/rtl/cls_cmd_if.sv
hw/rtl/cls_result_if.sv
hw/rtl/cls_rekey.sv
hw/rtl/combination_lock_with_serial_rekey_top.sv
verif/tb_combination_lock_with_serial_rekey_top.sv
